@@ design/assert_macros.svh @@
// Assertion macros for the RTL of the unique FIFO queue.
// Included by uqf_datapath, which checks its own logic; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define UQF_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`define UQF_ASSERT_NEXT(label, clk, rst_n, trig, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) \
        else $error(msg);

`else

`define UQF_ASSERT(label, clk, rst_n, prop, msg)

`define UQF_ASSERT_NEXT(label, clk, rst_n, trig, cons, msg)

`endif

`endif

@@ design/uqf_pkg.sv @@
// Package for the unique FIFO queue: request and status codes, controller
// states and the command/status structs between controller and datapath.
// No dependencies.
package uqf_pkg;

    localparam int DEPTH_DEF       = 16;
    localparam int VALUE_WIDTH_DEF = 32;
    localparam int VALUE_WIDTH_MAX = 64;

    localparam int CMD_W    = 2;
    localparam int ITEM_W   = 32;
    localparam int POS_W    = 4;
    localparam int STATUS_W = 3;
    localparam int CNT_W    = 5;

    localparam int S_DATA_W = 40;
    localparam int S_USER_W = CMD_W;
    localparam int M_DATA_W = 40;
    localparam int M_USER_W = STATUS_W;

    typedef enum logic [CMD_W-1:0] {
        CMD_ENQ  = 2'd0,
        CMD_DEQ  = 2'd1,
        CMD_READ = 2'd2,
        CMD_NOP  = 2'd3
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 3'd0,
        ST_DUP   = 3'd1,
        ST_FULL  = 3'd2,
        ST_EMPTY = 3'd3,
        ST_RANGE = 3'd4
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_SCAN,
        S_WRITE,
        S_FETCH,
        S_FINISH
    } state_t;

    typedef enum logic [1:0] {
        RA_HEAD,
        RA_POS,
        RA_WALK
    } rd_src_t;

    typedef struct packed {
        logic    latch;
        logic    rd_en;
        rd_src_t rd_src;
        logic    walk_start;
        logic    walk_step;
        logic    do_write;
        logic    do_pop;
        logic    take_rd;
        logic    st_load;
        status_t st_code;
        logic    out_load;
    } dp_cmd_t;

    typedef struct packed {
        cmd_t req_cmd;
        logic full;
        logic empty;
        logic pos_bad;
        logic match;
        logic scan_done;
        logic out_free;
    } dp_stat_t;

endpackage

@@ design/uqf_ctrl.sv @@
// Controller of the unique FIFO queue: request sequencing state machine.
// Depends on uqf_pkg; drives uqf_datapath through dp_cmd_t.
module uqf_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid_i,
    output logic              s_ready_o,
    input  uqf_pkg::dp_stat_t stat_i,
    output uqf_pkg::dp_cmd_t  cmd_o
);
    import uqf_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd_o      = '0;
        s_ready_o  = 1'b0;
        case (state_reg)
            S_IDLE: begin
                s_ready_o = 1'b1;
                if (s_valid_i) begin
                    cmd_o.latch = 1'b1;
                    state_next  = S_CHECK;
                end
            end
            S_CHECK: begin
                case (stat_i.req_cmd)
                    CMD_ENQ: begin
                        if (stat_i.full) begin
                            cmd_o.st_load = 1'b1;
                            cmd_o.st_code = ST_FULL;
                            state_next    = S_FINISH;
                        end else if (stat_i.empty) begin
                            state_next = S_WRITE;
                        end else begin
                            cmd_o.rd_en      = 1'b1;
                            cmd_o.rd_src     = RA_HEAD;
                            cmd_o.walk_start = 1'b1;
                            state_next       = S_SCAN;
                        end
                    end
                    CMD_DEQ: begin
                        if (stat_i.empty) begin
                            cmd_o.st_load = 1'b1;
                            cmd_o.st_code = ST_EMPTY;
                            state_next    = S_FINISH;
                        end else begin
                            cmd_o.rd_en  = 1'b1;
                            cmd_o.rd_src = RA_HEAD;
                            state_next   = S_FETCH;
                        end
                    end
                    CMD_READ: begin
                        if (stat_i.pos_bad) begin
                            cmd_o.st_load = 1'b1;
                            cmd_o.st_code = ST_RANGE;
                            state_next    = S_FINISH;
                        end else begin
                            cmd_o.rd_en  = 1'b1;
                            cmd_o.rd_src = RA_POS;
                            state_next   = S_FETCH;
                        end
                    end
                    default: begin
                        state_next = S_FINISH;
                    end
                endcase
            end
            S_SCAN: begin
                if (stat_i.match) begin
                    cmd_o.st_load = 1'b1;
                    cmd_o.st_code = ST_DUP;
                    state_next    = S_FINISH;
                end else if (stat_i.scan_done) begin
                    state_next = S_WRITE;
                end else begin
                    cmd_o.rd_en     = 1'b1;
                    cmd_o.rd_src    = RA_WALK;
                    cmd_o.walk_step = 1'b1;
                end
            end
            S_WRITE: begin
                cmd_o.do_write = 1'b1;
                state_next     = S_FINISH;
            end
            S_FETCH: begin
                cmd_o.take_rd = 1'b1;
                cmd_o.do_pop  = (stat_i.req_cmd == CMD_DEQ);
                state_next    = S_FINISH;
            end
            S_FINISH: begin
                if (stat_i.out_free) begin
                    cmd_o.out_load = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

@@ design/uqf_datapath.sv @@
// Datapath of the unique FIFO queue: entry memory, pointers, duplicate scan
// and result register. Depends on uqf_pkg and assert_macros.svh.
`include "assert_macros.svh"

module uqf_datapath #(
    parameter int DEPTH       = uqf_pkg::DEPTH_DEF,
    parameter int VALUE_WIDTH = uqf_pkg::VALUE_WIDTH_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  uqf_pkg::dp_cmd_t              cmd_i,
    output uqf_pkg::dp_stat_t             stat_o,
    input  logic [uqf_pkg::S_DATA_W-1:0]  s_tdata,
    input  logic [uqf_pkg::S_USER_W-1:0]  s_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [uqf_pkg::M_DATA_W-1:0]  m_tdata,
    output logic [uqf_pkg::M_USER_W-1:0]  m_tuser
);
    import uqf_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int OW = $clog2(DEPTH + 1);
    localparam int CW = (OW > POS_W) ? OW : POS_W;
    localparam int SW = ((AW > POS_W) ? AW : POS_W) + 1;
    localparam int EW = (OW > CNT_W) ? OW : CNT_W;

    function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] p);
        if (p == AW'(DEPTH - 1)) begin
            return '0;
        end
        return p + 1'b1;
    endfunction

    logic [VALUE_WIDTH-1:0] mem [DEPTH];

    cmd_t                   req_cmd_reg;
    logic [VALUE_WIDTH-1:0] item_reg;
    logic [POS_W-1:0]       pos_reg;
    logic [AW-1:0]          head_reg;
    logic [AW-1:0]          tail_reg;
    logic [AW-1:0]          walk_reg;
    logic [OW-1:0]          occ_reg;
    logic [OW-1:0]          cnt_reg;
    logic [VALUE_WIDTH-1:0] rd_data_reg;
    logic [ITEM_W-1:0]      val_reg;
    status_t                status_reg;
    logic                   out_valid_reg;
    logic [ITEM_W-1:0]      out_data_reg;
    status_t                out_status_reg;
    logic [CNT_W-1:0]       out_count_reg;

    logic [VALUE_WIDTH_MAX-1:0]   item_wide;
    logic signed [VALUE_WIDTH-1:0] rd_signed;
    logic [VALUE_WIDTH_MAX-1:0]   rd_wide;
    logic [SW-1:0]                sum_pos;
    logic [AW-1:0]                slot_pos;
    logic [AW-1:0]                rd_addr;
    logic [EW-1:0]                occ_ext;

    assign item_wide = VALUE_WIDTH_MAX'(s_tdata[ITEM_W-1:0]);
    assign rd_signed = rd_data_reg;
    assign rd_wide   = VALUE_WIDTH_MAX'(rd_signed);
    assign sum_pos   = SW'(head_reg) + SW'(pos_reg);
    assign slot_pos  = (sum_pos >= SW'(DEPTH)) ? AW'(sum_pos - SW'(DEPTH)) : AW'(sum_pos);
    assign occ_ext   = EW'(occ_reg);

    always_comb begin
        case (cmd_i.rd_src)
            RA_HEAD: rd_addr = head_reg;
            RA_POS:  rd_addr = slot_pos;
            RA_WALK: rd_addr = walk_reg;
            default: rd_addr = head_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (cmd_i.do_write) begin
            mem[tail_reg] <= item_reg;
        end
        if (cmd_i.rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg      <= '0;
            tail_reg      <= '0;
            occ_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cmd_i.do_write) begin
                tail_reg <= wrap_inc(tail_reg);
                occ_reg  <= occ_reg + 1'b1;
            end else if (cmd_i.do_pop) begin
                head_reg <= wrap_inc(head_reg);
                occ_reg  <= occ_reg - 1'b1;
            end
            if (cmd_i.out_load) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd_i.latch) begin
            req_cmd_reg <= cmd_t'(s_tuser);
            item_reg    <= item_wide[VALUE_WIDTH-1:0];
            pos_reg     <= s_tdata[ITEM_W+POS_W-1:ITEM_W];
            val_reg     <= '0;
            status_reg  <= ST_OK;
        end else begin
            if (cmd_i.take_rd) begin
                val_reg <= rd_wide[ITEM_W-1:0];
            end
            if (cmd_i.st_load) begin
                status_reg <= cmd_i.st_code;
            end
        end
        if (cmd_i.walk_start) begin
            walk_reg <= wrap_inc(head_reg);
            cnt_reg  <= OW'(1);
        end else if (cmd_i.walk_step) begin
            walk_reg <= wrap_inc(walk_reg);
            cnt_reg  <= cnt_reg + 1'b1;
        end
        if (cmd_i.out_load) begin
            out_data_reg   <= val_reg;
            out_status_reg <= status_reg;
            out_count_reg  <= occ_ext[CNT_W-1:0];
        end
    end

    assign stat_o.req_cmd   = req_cmd_reg;
    assign stat_o.full      = (occ_reg == OW'(DEPTH));
    assign stat_o.empty     = (occ_reg == '0);
    assign stat_o.pos_bad   = (CW'(pos_reg) >= CW'(occ_reg));
    assign stat_o.match     = (rd_data_reg == item_reg);
    assign stat_o.scan_done = (cnt_reg == occ_reg);
    assign stat_o.out_free  = !out_valid_reg || m_tready;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = M_DATA_W'({out_count_reg, out_data_reg});
    assign m_tuser  = out_status_reg;

    `UQF_ASSERT(a_occ_bound, aclk, aresetn, occ_reg <= OW'(DEPTH), "occupancy above depth")
    `UQF_ASSERT(a_write_not_full, aclk, aresetn, cmd_i.do_write |-> !stat_o.full, "write when full")
    `UQF_ASSERT(a_pop_not_empty, aclk, aresetn, cmd_i.do_pop |-> !stat_o.empty, "pop when empty")
    `UQF_ASSERT(a_load_free, aclk, aresetn, cmd_i.out_load |-> (!out_valid_reg || m_tready), "result overwritten")
    `UQF_ASSERT_NEXT(a_write_grows, aclk, aresetn, cmd_i.do_write, occ_reg == $past(occ_reg) + 1'b1, "occupancy not advanced")

endmodule

@@ design/unique_fifo_queue.sv @@
// Channel  Dir  tdata                                          tuser
// s_       in   [31:0] item_value, [35:32] entry_position       [1:0] cmd
// m_       out  [31:0] read_value, [36:32] entry_count          [2:0] status
//
// One request at a time, from input transfer to earliest result transfer: dequeue
// and read pass S_CHECK, S_FETCH, S_FINISH; no-op, full, empty and out-of-range go
// from S_CHECK to S_FINISH. An accepted enqueue scans the held entries before S_WRITE;
// a duplicate ends the scan at its match; the scan reads one held entry per cycle.
// Reset (aresetn low, synchronous) empties the queue; entry memory is not cleared.
// A waiting result does not block the next transfer in; only the finish of the
// following request waits for m_tready.
// Top level of the unique FIFO queue. Depends on uqf_pkg, uqf_ctrl, uqf_datapath.
module unique_fifo_queue #(
    parameter int DEPTH       = uqf_pkg::DEPTH_DEF,
    parameter int VALUE_WIDTH = uqf_pkg::VALUE_WIDTH_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [uqf_pkg::S_DATA_W-1:0]  s_tdata,   // item_value, entry_position
    input  logic [uqf_pkg::S_USER_W-1:0]  s_tuser,   // cmd
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [uqf_pkg::M_DATA_W-1:0]  m_tdata,   // read_value, entry_count
    output logic [uqf_pkg::M_USER_W-1:0]  m_tuser    // status
);
    import uqf_pkg::*;

    dp_cmd_t  dp_cmd;
    dp_stat_t dp_stat;

    uqf_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid_i (s_tvalid),
        .s_ready_o (s_tready),
        .stat_i    (dp_stat),
        .cmd_o     (dp_cmd)
    );

    uqf_datapath #(
        .DEPTH       (DEPTH),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd_i    (dp_cmd),
        .stat_o   (dp_stat),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule
